@@ rtl/dorq_pkg.sv @@
`default_nettype none
package dorq_pkg;

  // Fixed field widths of the request and result ports
  localparam int ID_W      = 10;
  localparam int IN_DL_W   = 32;
  localparam int OUT_DL_W  = 32;
  localparam int OUT_CNT_W = 6;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ENQ      = 6'b000010,
    S_ENQ_LAST = 6'b000100,
    S_DEQ      = 6'b001000,
    S_HEAD_RD  = 6'b010000,
    S_HEAD_OUT = 6'b100000
  } fsm_t;

endpackage
`default_nettype wire

@@ rtl/deadline_ordered_ready_queue_top.sv @@
// Deadline-ordered ready queue.
// Request channel: drive start high with in_opcode, in_task_id and in_deadline
// while busy is low; the request is taken at that clock edge. An enqueue puts
// the task behind every held task with an earlier or equal deadline; a
// dequeue removes the held copy of in_task_id nearest the head.
// Result channel: exactly one result per request, shown for one cycle with
// out_valid high: head task (earliest deadline), held count and status.
// The receiver cannot stall; results must be taken when out_valid is high.
// The entries live sorted in a single RAM with one read and one write port.
// A request walks the held entries one entry per cycle, an enqueue from the
// tail until it finds its place, a dequeue over all of them; then the head
// entry is read for the result. A dropped request (full queue, or a dequeue
// on an empty queue) only reads the head. busy falls together with out_valid,
// so the next request may be taken in the cycle the result is shown.
// Reset (rst_n low, synchronous) empties the queue at once; the RAM contents
// are not cleared, since only entries below the held count are ever used.
`default_nettype none
module deadline_ordered_ready_queue_top
  import dorq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 32,
  parameter int DEADLINE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_opcode,
  input  wire logic [ID_W-1:0]      in_task_id,
  input  wire logic [IN_DL_W-1:0]   in_deadline,
  output logic                      out_valid,
  output logic                      out_head_valid,
  output logic [ID_W-1:0]           out_head_task_id,
  output logic [OUT_DL_W-1:0]       out_head_deadline,
  output logic [OUT_CNT_W-1:0]      out_queued_count,
  output logic [1:0]                out_status
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = DEADLINE_BITS;
  localparam int EW = ID_W + DW;

  fsm_t              state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              found_r, found_nxt;
  status_t           status_r, status_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [DW-1:0]     dl_r, dl_nxt;

  logic              out_valid_r;
  logic              head_valid_r;
  logic [ID_W-1:0]   head_id_r;
  logic [OUT_DL_W-1:0] head_dl_r;
  logic [OUT_CNT_W-1:0] count_out_r;
  status_t           status_out_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [EW-1:0]     rd_data;
  logic [ID_W-1:0]   rd_id;
  logic [DW-1:0]     rd_dl;
  logic              accept;
  logic              last_deq;
  logic              hit;

  dorq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_id    = rd_data[EW-1:DW];
  assign rd_dl    = rd_data[DW-1:0];
  assign accept   = start && (state_r == S_IDLE);
  assign hit      = (rd_id == id_r);
  assign last_deq = (idx_r == AW'(count_r - CW'(1)));

  // Sequence the walk over the store: read one entry a cycle, write back shifted
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    id_nxt     = id_r;
    dl_nxt     = dl_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = {id_r, dl_r};
    rd_en      = 1'b0;
    rd_addr    = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          id_nxt     = in_task_id;
          dl_nxt     = DW'(in_deadline);
          status_nxt = ST_DONE;
          found_nxt  = 1'b0;
          if (in_opcode == OP_ENQUEUE) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_HEAD_RD;
            end else if (count_r == '0) begin
              state_nxt = S_ENQ_LAST;
            end else begin
              // Start from the tail and move towards the head
              rd_en     = 1'b1;
              rd_addr   = AW'(count_r - CW'(1));
              idx_nxt   = AW'(count_r - CW'(1));
              state_nxt = S_ENQ;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_HEAD_RD;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              idx_nxt   = '0;
              state_nxt = S_DEQ;
            end
          end
        end
      end
      S_ENQ: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        if (rd_dl > dl_r) begin
          // Later deadline: shift it one slot back
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_ENQ_LAST;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = idx_r - AW'(1);
            idx_nxt   = idx_r - AW'(1);
          end
        end else begin
          // Earlier or equal deadline: the new task goes right behind it
          wr_data   = {id_r, dl_r};
          count_nxt = count_r + CW'(1);
          state_nxt = S_HEAD_RD;
        end
      end
      S_ENQ_LAST: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = {id_r, dl_r};
        count_nxt = count_r + CW'(1);
        state_nxt = S_HEAD_RD;
      end
      S_DEQ: begin
        // Past the removed entry, close the gap
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = idx_r - AW'(1);
          wr_data = rd_data;
        end else if (hit) begin
          found_nxt = 1'b1;
        end
        if (last_deq) begin
          if (found_r || hit) begin
            count_nxt = count_r - CW'(1);
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_HEAD_RD;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_HEAD_RD: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        state_nxt = S_HEAD_OUT;
      end
      S_HEAD_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_HEAD_OUT);
    end
  end

  // Request payload and walk position
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    id_r     <= id_nxt;
    dl_r     <= dl_nxt;
  end

  // Capture the result from the head entry
  always_ff @(posedge clk) begin
    if (state_r == S_HEAD_OUT) begin
      head_valid_r <= (count_r != '0);
      head_id_r    <= (count_r != '0) ? rd_id : '0;
      head_dl_r    <= (count_r != '0) ? OUT_DL_W'(rd_dl) : '0;
      count_out_r  <= OUT_CNT_W'(count_r);
      status_out_r <= status_r;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_head_valid    = head_valid_r;
  assign out_head_task_id  = head_id_r;
  assign out_head_deadline = head_dl_r;
  assign out_queued_count  = count_out_r;
  assign out_status        = status_out_r;

endmodule
`default_nettype wire

@@ rtl/dorq_ram.sv @@
`default_nettype none
module dorq_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and registered read port (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
